[sv/ffsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg : shared constants and arithmetic for the face flux scatter-add
// Field widths, cell store geometry, command codes, rounding and saturation.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Cell store geometry
  localparam int CELL_COUNT = 4096;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  // Request field widths
  localparam int IDX_W  = 12;
  localparam int CFG_W  = 13;
  localparam int COEF_W = 32;

  // Arithmetic widths: Q16.16 operands, Q32.32 products, Q32.16 sums
  localparam int PROD_W  = 2 * COEF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int FRAC_W  = 16;
  localparam int FLUX_W  = ACC_W - FRAC_W;
  localparam int EXT_W   = FLUX_W + 1;
  localparam int SUM_W   = 48;
  localparam int ENTRY_W = 3 * SUM_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] INTERIOR_RST = CFG_W'(4096);

  // Command codes
  localparam logic [1:0] FUNC_ACC   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Flux component selects
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Multiply sequence: three products for each of three components
  localparam int          MUL_STEPS = 9;
  localparam int          STEP_W    = $clog2(MUL_STEPS);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);

  // Round an exact Q34.32 dot product half up to Q34.16
  function automatic logic signed [FLUX_W-1:0] round_q(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = a + ACC_W'(1 << (FRAC_W - 1));
    return s[ACC_W-1:FRAC_W];
  endfunction

  // Add or subtract a flux from a stored sum, clamping to the 48-bit range
  function automatic logic signed [SUM_W-1:0] sat_upd(input logic signed [SUM_W-1:0] old,
                                                      input logic signed [FLUX_W-1:0] flux,
                                                      input logic sub);
    logic signed [EXT_W-1:0] s;
    logic signed [SUM_W-1:0] r;
    if (sub) begin
      s = EXT_W'(old) - EXT_W'(flux);
    end else begin
      s = EXT_W'(old) + EXT_W'(flux);
    end
    if ((s[EXT_W-1:SUM_W-1] == '0) || (s[EXT_W-1:SUM_W-1] == '1)) begin
      r = s[SUM_W-1:0];
    end else if (s[EXT_W-1]) begin
      r = SUM_MIN;
    end else begin
      r = SUM_MAX;
    end
    return r;
  endfunction

endpackage

[sv/face_flux_scatter_accumulate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_flux_scatter_accumulate : finite-volume face flux scatter-add
// Forms flux = T * A per face and scatters it into a cell sum store:
// subtract from the left cell, add to an interior right cell. Also reads
// back or clears one cell.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ----------------------------------
//  request   in_func .. in_area_z           taken when start high, busy low
//  result    out_sum_x/y/z                  out_valid strobe, one cycle
//  config    cfg_wdata (interior_cells)     written when cfg_we high
//
// Sequence: an accumulate request keeps busy high while its nine products go
// through the single 32x32 multiplier, the last drains, the flux is rounded,
// then a read-modify-write of the left cell and one of the right cell go over
// the one write port of the cell store. A read keeps busy high through S_RD
// and S_RSP; its result strobes in the cycle after. A clear holds busy in
// S_CLR only. Reset: the cell store is swept to zero, one entry a cycle, over
// CELL_COUNT (4096) entries, with busy high; config writes are still taken.
// The result side cannot stall; results leave through output registers.
// ----------------------------------------------------------------------------
module face_flux_scatter_accumulate (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              in_func,
  input  logic [ffsa_pkg::IDX_W-1:0]              in_left_cell,
  input  logic [ffsa_pkg::IDX_W-1:0]              in_right_cell,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_t_xx,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_t_xy,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_t_xz,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_t_yy,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_t_yz,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_t_zz,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_area_x,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_area_y,
  input  logic signed [ffsa_pkg::COEF_W-1:0]      in_area_z,
  input  logic                                    cfg_we,
  input  logic [ffsa_pkg::CFG_W-1:0]              cfg_wdata,
  output logic                                    out_valid,
  output logic signed [ffsa_pkg::SUM_W-1:0]       out_sum_x,
  output logic signed [ffsa_pkg::SUM_W-1:0]       out_sum_y,
  output logic signed [ffsa_pkg::SUM_W-1:0]       out_sum_z
);

  typedef enum logic [10:0] {
    S_SWEEP = 11'b000_0000_0001,  // reset clearing pass
    S_IDLE  = 11'b000_0000_0010,
    S_MUL   = 11'b000_0000_0100,  // one product a cycle
    S_ACC   = 11'b000_0000_1000,  // drain the last product
    S_RND   = 11'b000_0001_0000,  // round flux, read left cell
    S_WRL   = 11'b000_0010_0000,  // subtract, write left cell
    S_RDR   = 11'b000_0100_0000,  // read right cell
    S_WRR   = 11'b000_1000_0000,  // add, write right cell
    S_RD    = 11'b001_0000_0000,  // read cell for a read request
    S_RSP   = 11'b010_0000_0000,  // load result registers
    S_CLR   = 11'b100_0000_0000   // clear one cell
  } state_t;

  state_t state_r, state_nxt;

  logic accept;

  // Configuration
  logic [ffsa_pkg::CFG_W-1:0] interior_r;

  // Captured request
  logic [1:0]                          func_r;
  logic [ffsa_pkg::CELL_AW-1:0]        laddr_r, raddr_r;
  logic                                lok_r, rok_r;
  logic signed [ffsa_pkg::COEF_W-1:0]  xx_r, xy_r, xz_r, yy_r, yz_r, zz_r;
  logic signed [ffsa_pkg::COEF_W-1:0]  ax_r, ay_r, az_r;

  // Multiply-accumulate
  logic [ffsa_pkg::STEP_W-1:0]         step_r;
  logic signed [ffsa_pkg::COEF_W-1:0]  op_a, op_b;
  logic [1:0]                          op_comp;
  logic signed [ffsa_pkg::PROD_W-1:0]  prod_r;
  logic [1:0]                          prod_comp_r;
  logic                                prod_vld_r;
  logic signed [ffsa_pkg::ACC_W-1:0]   acc_x_r, acc_y_r, acc_z_r;
  logic signed [ffsa_pkg::FLUX_W-1:0]  flux_x_r, flux_y_r, flux_z_r;

  // Cell store
  logic [ffsa_pkg::ENTRY_W-1:0]        mem [ffsa_pkg::CELL_COUNT];
  logic [ffsa_pkg::ENTRY_W-1:0]        rd_data_r;
  logic                                mem_re, mem_we;
  logic [ffsa_pkg::CELL_AW-1:0]        mem_raddr, mem_waddr;
  logic [ffsa_pkg::ENTRY_W-1:0]        mem_wdata;
  logic [ffsa_pkg::CELL_AW-1:0]        sweep_r;

  logic signed [ffsa_pkg::SUM_W-1:0]   old_x, old_y, old_z;
  logic signed [ffsa_pkg::SUM_W-1:0]   new_x, new_y, new_z;
  logic                                upd_sub;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_r == ffsa_pkg::CELL_AW'(ffsa_pkg::CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (in_func)
            ffsa_pkg::FUNC_ACC:   state_nxt = S_MUL;
            ffsa_pkg::FUNC_READ:  state_nxt = S_RD;
            ffsa_pkg::FUNC_CLEAR: state_nxt = S_CLR;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        if (step_r == ffsa_pkg::MUL_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC:   state_nxt = S_RND;
      S_RND:   state_nxt = S_WRL;
      S_WRL:   state_nxt = S_RDR;
      S_RDR:   state_nxt = S_WRR;
      S_WRR:   state_nxt = S_IDLE;
      S_RD:    state_nxt = S_RSP;
      S_RSP:   state_nxt = S_IDLE;
      S_CLR:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      sweep_r    <= '0;
      step_r     <= '0;
      prod_vld_r <= 1'b0;
      out_valid  <= 1'b0;
      interior_r <= ffsa_pkg::INTERIOR_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SWEEP) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (accept) begin
        step_r <= '0;
      end else if (state_r == S_MUL) begin
        step_r <= step_r + 1'b1;
      end
      prod_vld_r <= (state_r == S_MUL);
      out_valid  <= (state_r == S_RSP);
      if (cfg_we) begin
        interior_r <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request capture: decide cell range and ghost status up front
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      laddr_r <= ffsa_pkg::CELL_AW'(in_left_cell);
      raddr_r <= ffsa_pkg::CELL_AW'(in_right_cell);
      lok_r   <= (32'(in_left_cell) < ffsa_pkg::CELL_COUNT);
      rok_r   <= (32'(in_right_cell) < ffsa_pkg::CELL_COUNT) &&
                 (ffsa_pkg::CFG_W'(in_right_cell) < interior_r);
      xx_r <= in_t_xx;
      xy_r <= in_t_xy;
      xz_r <= in_t_xz;
      yy_r <= in_t_yy;
      yz_r <= in_t_yz;
      zz_r <= in_t_zz;
      ax_r <= in_area_x;
      ay_r <= in_area_y;
      az_r <= in_area_z;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: walk the rows of T against A
  // --------------------------------------------------------------------------
  always_comb begin
    case (step_r)
      4'd0:    begin op_a = xx_r; op_b = ax_r; op_comp = ffsa_pkg::COMP_X; end
      4'd1:    begin op_a = xy_r; op_b = ay_r; op_comp = ffsa_pkg::COMP_X; end
      4'd2:    begin op_a = xz_r; op_b = az_r; op_comp = ffsa_pkg::COMP_X; end
      4'd3:    begin op_a = xy_r; op_b = ax_r; op_comp = ffsa_pkg::COMP_Y; end
      4'd4:    begin op_a = yy_r; op_b = ay_r; op_comp = ffsa_pkg::COMP_Y; end
      4'd5:    begin op_a = yz_r; op_b = az_r; op_comp = ffsa_pkg::COMP_Y; end
      4'd6:    begin op_a = xz_r; op_b = ax_r; op_comp = ffsa_pkg::COMP_Z; end
      4'd7:    begin op_a = yz_r; op_b = ay_r; op_comp = ffsa_pkg::COMP_Z; end
      4'd8:    begin op_a = zz_r; op_b = az_r; op_comp = ffsa_pkg::COMP_Z; end
      default: begin op_a = '0;   op_b = '0;   op_comp = ffsa_pkg::COMP_X; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r      <= ffsa_pkg::PROD_W'(op_a) * ffsa_pkg::PROD_W'(op_b);
      prod_comp_r <= op_comp;
    end
    // Sums stay exact; round once all three products are in
    if (accept) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else if (prod_vld_r) begin
      case (prod_comp_r)
        ffsa_pkg::COMP_X: acc_x_r <= acc_x_r + ffsa_pkg::ACC_W'(prod_r);
        ffsa_pkg::COMP_Y: acc_y_r <= acc_y_r + ffsa_pkg::ACC_W'(prod_r);
        default:          acc_z_r <= acc_z_r + ffsa_pkg::ACC_W'(prod_r);
      endcase
    end
    if (state_r == S_RND) begin
      flux_x_r <= ffsa_pkg::round_q(acc_x_r);
      flux_y_r <= ffsa_pkg::round_q(acc_y_r);
      flux_z_r <= ffsa_pkg::round_q(acc_z_r);
    end
  end

  // --------------------------------------------------------------------------
  // Read-modify-write of the cell store. Left write lands before the right
  // read is issued, so a face whose cells coincide needs no forwarding.
  // --------------------------------------------------------------------------
  assign old_x   = rd_data_r[ffsa_pkg::SUM_W-1:0];
  assign old_y   = rd_data_r[2*ffsa_pkg::SUM_W-1:ffsa_pkg::SUM_W];
  assign old_z   = rd_data_r[3*ffsa_pkg::SUM_W-1:2*ffsa_pkg::SUM_W];
  assign upd_sub = (state_r == S_WRL);
  assign new_x   = ffsa_pkg::sat_upd(old_x, flux_x_r, upd_sub);
  assign new_y   = ffsa_pkg::sat_upd(old_y, flux_y_r, upd_sub);
  assign new_z   = ffsa_pkg::sat_upd(old_z, flux_z_r, upd_sub);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = laddr_r;
    mem_we    = 1'b0;
    mem_waddr = laddr_r;
    mem_wdata = {new_z, new_y, new_x};
    case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = '0;
      end
      S_RND, S_RD: begin
        mem_re = 1'b1;
      end
      S_RDR: begin
        mem_re    = 1'b1;
        mem_raddr = raddr_r;
      end
      S_WRL: begin
        mem_we = lok_r;
      end
      S_WRR: begin
        mem_we    = rok_r;
        mem_waddr = raddr_r;
      end
      S_CLR: begin
        mem_we    = lok_r;
        mem_wdata = '0;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Result registers: drop to zero for a cell beyond the store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if ((state_r == S_RSP) && (func_r == ffsa_pkg::FUNC_READ)) begin
      out_sum_x <= lok_r ? old_x : '0;
      out_sum_y <= lok_r ? old_y : '0;
      out_sum_z <= lok_r ? old_z : '0;
    end
  end

endmodule
